/* design/apsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared constants, codes and controller/datapath command types for the
// all-pairs shortest path unit.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [6:0] VCOUNT_RESET = 7'd64;
    localparam logic [6:0] UNREACH_CODE = 7'd127;
    localparam logic [6:0] MAX_CODE     = 7'd126;
    localparam logic [6:0] DIST_SAT     = 7'd63;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_RELAX = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_CLR,
        DP_EDGE_AB,
        DP_EDGE_BA,
        DP_FW_RD_IK,
        DP_FW_CHK,
        DP_FW_RD_J,
        DP_FW_WR_J,
        DP_Q_OUT,
        DP_DONE_OUT
    } t_dp_op;

    typedef struct packed {
        logic   accept;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic ik_unreach;
        logic j_last;
        logic i_last;
        logic k_last;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_EDGE_AB,
        S_EDGE_BA,
        S_FW_IK,
        S_FW_CHK,
        S_FW_RD,
        S_FW_WR,
        S_QOUT,
        S_DONE
    } t_state;

endpackage

/* design/apsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface apsp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
    modport source (output valid, mode, vertex_a, vertex_b, input ready);
    modport sink   (input valid, mode, vertex_a, vertex_b, output ready);
endinterface

interface apsp_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] distance;
    logic       unreachable;
    logic       done_res;
    modport source (output valid, distance, unreachable, done_res, input ready);
    modport sink   (input valid, distance, unreachable, done_res, output ready);
endinterface

interface apsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* design/apsp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_datapath
// Distance matrix memory, loop counters, relaxation adder and result register.
// ----------------------------------------------------------------------------
module apsp_datapath #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  apsp_pkg::t_dp_cmd     i_cmd,
    output apsp_pkg::t_dp_status  o_status,
    input  logic [6:0]            i_vertex_count,
    input  logic [5:0]            i_vertex_a,
    input  logic [5:0]            i_vertex_b,
    output logic [5:0]            o_distance,
    output logic                  o_unreachable,
    output logic                  o_done_res
);
    import apsp_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NW > 7) ? NW : 7;
    localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

    logic [6:0] mem [DEPTH];
    logic [6:0] r_rd_a;
    logic [6:0] r_rd_b;

    logic [CW-1:0] r_n;
    logic [VW-1:0] r_a, r_b;
    logic          r_edge_ok;
    logic          r_q_oob;
    logic [6:0]    r_ik;
    logic [VW-1:0] r_k, r_i, r_j;
    logic [VW-1:0] r_cr, r_cc;
    logic [5:0]    r_out_dist;
    logic          r_out_unr;
    logic          r_out_done;

    logic [CW-1:0] w_vc, w_n, w_nm1, w_a, w_b;
    logic [5:0]    w_lo, w_hi;
    logic [AW-1:0] w_raddr_a, w_raddr_b, w_waddr;
    logic [6:0]    w_wdata;
    logic          w_we;
    logic [7:0]    w_sum;
    logic [6:0]    w_sum_sat;
    logic          w_adv_i;

    // Active vertex count, held in range 1 .. MAX_VERTICES.
    always_comb begin
        w_vc = CW'(i_vertex_count);
        if (w_vc == '0) begin
            w_n = CW'(1);
        end else if (w_vc > CW'(MAX_VERTICES)) begin
            w_n = CW'(MAX_VERTICES);
        end else begin
            w_n = w_vc;
        end
        w_a   = CW'(i_vertex_a);
        w_b   = CW'(i_vertex_b);
        w_lo  = (i_vertex_a < i_vertex_b) ? i_vertex_a : i_vertex_b;
        w_hi  = (i_vertex_a < i_vertex_b) ? i_vertex_b : i_vertex_a;
        w_nm1 = r_n - CW'(1);
    end

    assign w_sum     = {1'b0, r_ik} + {1'b0, r_rd_a};
    assign w_sum_sat = (w_sum > {1'b0, MAX_CODE}) ? MAX_CODE : w_sum[6:0];

    assign o_status.clr_last   = (r_cr == LAST_IDX) && (r_cc == LAST_IDX);
    assign o_status.ik_unreach = (r_rd_a == UNREACH_CODE);
    assign o_status.j_last     = (CW'(r_j) == w_nm1);
    assign o_status.i_last     = (CW'(r_i) == w_nm1);
    assign o_status.k_last     = (CW'(r_k) == w_nm1);

    always_comb begin
        w_raddr_a = {r_k, r_j};
        w_raddr_b = {r_i, r_j};
        if (i_cmd.accept) begin
            w_raddr_a = {VW'(w_lo), VW'(w_hi)};
        end else if (i_cmd.op == DP_FW_RD_IK) begin
            w_raddr_a = {r_i, r_k};
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_i, r_j};
        w_wdata = w_sum_sat;
        w_adv_i = 1'b0;
        case (i_cmd.op)
            DP_CLR: begin
                w_we    = 1'b1;
                w_waddr = {r_cr, r_cc};
                w_wdata = (r_cr == r_cc) ? 7'd0 : UNREACH_CODE;
            end
            DP_EDGE_AB: begin
                w_we    = r_edge_ok;
                w_waddr = {r_a, r_b};
                w_wdata = 7'd1;
            end
            DP_EDGE_BA: begin
                w_we    = r_edge_ok;
                w_waddr = {r_b, r_a};
                w_wdata = 7'd1;
            end
            DP_FW_CHK: begin
                w_adv_i = o_status.ik_unreach;
            end
            DP_FW_WR_J: begin
                w_we    = (r_rd_a != UNREACH_CODE) && (w_sum_sat < r_rd_b);
                w_adv_i = o_status.j_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= mem[w_raddr_a];
        r_rd_b <= mem[w_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_i  <= '0;
            r_j  <= '0;
            r_cr <= '0;
            r_cc <= '0;
        end else begin
            if (i_cmd.op == DP_CLR) begin
                if (r_cc == LAST_IDX) begin
                    r_cc <= '0;
                    r_cr <= (r_cr == LAST_IDX) ? '0 : r_cr + VW'(1);
                end else begin
                    r_cc <= r_cc + VW'(1);
                end
            end
            if (i_cmd.op == DP_FW_WR_J) begin
                r_j <= o_status.j_last ? '0 : r_j + VW'(1);
            end
            if (w_adv_i) begin
                if (o_status.i_last) begin
                    r_i <= '0;
                    r_k <= o_status.k_last ? '0 : r_k + VW'(1);
                end else begin
                    r_i <= r_i + VW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_n       <= w_n;
            r_a       <= VW'(i_vertex_a);
            r_b       <= VW'(i_vertex_b);
            r_edge_ok <= (w_a < w_n) && (w_b < w_n) && (i_vertex_a != i_vertex_b);
            r_q_oob   <= (CW'(w_hi) >= w_n);
        end
        if (i_cmd.op == DP_FW_CHK) begin
            r_ik <= r_rd_a;
        end
        if (i_cmd.op == DP_Q_OUT) begin
            r_out_done <= 1'b0;
            if (r_q_oob || (r_rd_a == UNREACH_CODE)) begin
                r_out_dist <= 6'd0;
                r_out_unr  <= 1'b1;
            end else begin
                r_out_dist <= (r_rd_a > DIST_SAT) ? 6'd63 : r_rd_a[5:0];
                r_out_unr  <= 1'b0;
            end
        end
        if (i_cmd.op == DP_DONE_OUT) begin
            r_out_dist <= 6'd0;
            r_out_unr  <= 1'b0;
            r_out_done <= 1'b1;
        end
    end

    assign o_distance    = r_out_dist;
    assign o_unreachable = r_out_unr;
    assign o_done_res    = r_out_done;

endmodule

/* design/apsp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_ctrl
// Sequencer for clearing, edge loads, relaxation and queries.
// ----------------------------------------------------------------------------
module apsp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_mode,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output apsp_pkg::t_dp_cmd    o_cmd,
    input  apsp_pkg::t_dp_status i_status
);
    import apsp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.accept = w_in_fire;
        o_cmd.op     = DP_IDLE;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = DP_CLR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: n_state = S_CLR;
                        MODE_EDGE:  n_state = S_EDGE_AB;
                        MODE_RELAX: n_state = S_FW_IK;
                        MODE_QUERY: n_state = S_QOUT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.op = DP_CLR;
                if (i_status.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_EDGE_AB: begin
                o_cmd.op = DP_EDGE_AB;
                n_state  = S_EDGE_BA;
            end
            S_EDGE_BA: begin
                o_cmd.op = DP_EDGE_BA;
                n_state  = S_DONE;
            end
            S_FW_IK: begin
                o_cmd.op = DP_FW_RD_IK;
                n_state  = S_FW_CHK;
            end
            S_FW_CHK: begin
                o_cmd.op = DP_FW_CHK;
                if (!i_status.ik_unreach) begin
                    n_state = S_FW_RD;
                end else if (i_status.i_last && i_status.k_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FW_IK;
                end
            end
            S_FW_RD: begin
                o_cmd.op = DP_FW_RD_J;
                n_state  = S_FW_WR;
            end
            S_FW_WR: begin
                o_cmd.op = DP_FW_WR_J;
                if (!i_status.j_last) begin
                    n_state = S_FW_RD;
                end else if (i_status.i_last && i_status.k_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FW_IK;
                end
            end
            S_QOUT: begin
                o_cmd.op    = DP_Q_OUT;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_DONE: begin
                o_cmd.op    = DP_DONE_OUT;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/all_pairs_shortest_path_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_unit
// Hop-distance matrix with clear, edge load, Floyd-Warshall relaxation and
// pair query over a single distance memory.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the whole distance memory, MAX_VERTICES
// squared entries, accepting no item, to set every pair unreachable and the
// diagonal to zero; configuration writes are taken throughout. One item is
// handled at a time and its result sits in an output register, so the next
// item is taken as that result leaves. A query makes one registered memory
// read and then gives its result, an edge load writes one entry per direction
// and then the result, a clear writes one entry per cycle over MAX_VERTICES
// squared entries and then the result, and a relaxation over n active
// vertices fetches the leg of each intermediate and source pair and, if it is
// reachable, reads both legs of each target and conditionally writes back.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_unit #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apsp_in_if.sink    i_in,
    apsp_out_if.source o_out,
    apsp_cfg_if.sink   i_cfg
);
    import apsp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [6:0] r_vertex_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg.valid) begin
            r_vertex_count <= i_cfg.data;
        end
    end

    apsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    apsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_vertex_count (r_vertex_count),
        .i_vertex_a     (i_in.vertex_a),
        .i_vertex_b     (i_in.vertex_b),
        .o_distance     (o_out.distance),
        .o_unreachable  (o_out.unreachable),
        .o_done_res     (o_out.done_res)
    );

endmodule
